>>> hdl/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// lzwd_pkg
// shared types and constants for the lzw code decoder
// ----------------------------------------------------------------------------
package lzwd_pkg;
  localparam int unsigned MAX_CODE_BITS_DEF = 12;
  localparam int unsigned STACK_DEPTH_DEF   = 64;
  localparam int unsigned CODE_W            = 12;
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned CW_W              = 4;
  localparam logic [CW_W-1:0] START_CW_RST  = 4'd9;
  localparam int unsigned LITERAL_LIMIT     = 256;

  // classified code handed from front to back
  typedef struct packed {
    logic              first;   // first code of the stream
    logic [CODE_W-1:0] code;
  } lzwd_cmd_t;
endpackage

>>> hdl/lzwd_if.sv
// ----------------------------------------------------------------------------
// lzwd_code_if / lzwd_res_if
// valid/ready channels for codes and decoded bytes
// ----------------------------------------------------------------------------
interface lzwd_code_if;
  logic        valid;
  logic        ready;
  logic [11:0] code;
  modport source (output valid, output code, input ready);
  modport sink   (input valid, input code, output ready);
endinterface

interface lzwd_res_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_byte;
  logic       error;
  modport source (output valid, output data_byte, output last_byte, output error,
                  input ready);
  modport sink   (input valid, input data_byte, input last_byte, input error,
                  output ready);
endinterface

>>> hdl/lzwd_front.sv
// ----------------------------------------------------------------------------
// lzwd_front
// accepts codes, tracks width, drops widening codes, queues the rest
// ----------------------------------------------------------------------------
module lzwd_front
  import lzwd_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  logic [CW_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CODE_W-1:0] in_code,
  output logic              q_valid,
  input  logic              q_ready,
  output lzwd_cmd_t         q_cmd
);
  localparam int unsigned QD = 2;

  lzwd_cmd_t       q_mem_r [QD];
  logic            wp_r, rp_r;
  logic [1:0]      cnt_r;
  logic [CW_W-1:0] cw_r;
  logic            started_r;
  logic            acc, widen, push, pop;
  logic [16:0]     all_ones;

  assign in_ready = (cnt_r != 2'd2);
  assign acc      = in_valid && in_ready;
  assign all_ones = (17'd1 << cw_r) - 17'd1;
  assign widen    = started_r && ({5'd0, in_code} == all_ones);
  assign push     = acc && !widen;
  assign q_valid  = (cnt_r != 2'd0);
  assign pop      = q_valid && q_ready;
  assign q_cmd    = q_mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wp_r] <= '{first: !started_r, code: in_code};
    end
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= '0;
      cw_r <= START_CW_RST; started_r <= 1'b0;
    end else begin
      if (push) wp_r <= ~wp_r;
      if (pop)  rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, push} - {1'b0, pop};
      if (acc) started_r <= 1'b1;
      if (cfg_we && !started_r) cw_r <= cfg_wdata;
      else if (acc && widen && (32'(cw_r) < MAX_CODE_BITS)) cw_r <= cw_r + 4'd1;
    end
  end
endmodule

>>> hdl/lzwd_back.sv
// ----------------------------------------------------------------------------
// lzwd_back
// dictionary walk onto a byte stack, then pops bytes out
// ----------------------------------------------------------------------------
module lzwd_back
  import lzwd_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_valid,
  output logic              q_ready,
  input  lzwd_cmd_t         q_cmd,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [BYTE_W-1:0] out_data_byte,
  output logic              out_last_byte,
  output logic              out_error
);
  localparam int unsigned DSZ = 1 << MAX_CODE_BITS;
  localparam int unsigned AW  = MAX_CODE_BITS;
  localparam int unsigned SW  = $clog2(STACK_DEPTH);
  localparam int unsigned NW  = SW + 1;

  typedef enum logic [2:0] {S_IDLE, S_READ, S_WALK, S_POP, S_EXTRA, S_ERR} st_t;

  logic [CODE_W-1:0] prefix_mem [DSZ];
  logic [BYTE_W-1:0] suffix_mem [DSZ];
  logic [BYTE_W-1:0] stack_mem  [STACK_DEPTH];

  st_t               st_r;
  logic [AW:0]       next_free_r;
  logic [CODE_W-1:0] prev_r, cur_r, c_r;
  logic [BYTE_W-1:0] fop_r, first_r;
  logic              unk_r;
  logic [NW-1:0]     n_r, lim_r;
  logic [CODE_W-1:0] rd_pre_r;
  logic [BYTE_W-1:0] rd_suf_r;
  logic              ov_r;
  logic [BYTE_W-1:0] ob_r;
  logic              ol_r, oe_r, ov_nxt;
  logic              slot;
  logic              emit;
  logic [AW-1:0]     rd_ix;

  assign out_valid     = ov_r;
  assign out_data_byte = ob_r;
  assign out_last_byte = ol_r;
  assign out_error     = oe_r;
  assign slot          = !ov_r || out_ready;
  // the opening code goes straight to the output, so it waits for a free slot
  assign q_ready       = (st_r == S_IDLE) && (slot || !q_cmd.first);
  assign rd_ix         = c_r[AW-1:0];
  assign emit          = slot && ((st_r == S_IDLE && q_valid && q_cmd.first)
                                  || st_r == S_POP || st_r == S_EXTRA || st_r == S_ERR);
  assign ov_nxt        = emit || (ov_r && !out_ready);

  // dictionary read, one entry per cycle
  always_ff @(posedge clk) begin
    rd_pre_r <= prefix_mem[rd_ix];
    rd_suf_r <= suffix_mem[rd_ix];
  end

  always_ff @(posedge clk) begin
    if (st_r == S_WALK) begin
      stack_mem[n_r[SW-1:0]] <= (c_r < 12'(LITERAL_LIMIT)) ? c_r[BYTE_W-1:0] : rd_suf_r;
    end
    if (st_r == S_WALK && c_r < 12'(LITERAL_LIMIT) && n_r < lim_r
        && next_free_r < (AW+1)'(DSZ)) begin
      prefix_mem[next_free_r[AW-1:0]] <= prev_r;
      suffix_mem[next_free_r[AW-1:0]] <= c_r[BYTE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE; ov_r <= 1'b0; next_free_r <= (AW+1)'(LITERAL_LIMIT);
      prev_r <= '0; fop_r <= '0;
    end else begin
      ov_r <= ov_nxt;
      case (st_r)
        S_IDLE: if (q_valid) begin
          cur_r <= q_cmd.code;
          if (q_cmd.first) begin
            if (slot) begin
              ob_r <= q_cmd.code[BYTE_W-1:0]; ol_r <= 1'b1; oe_r <= 1'b0;
              prev_r <= q_cmd.code; fop_r <= q_cmd.code[BYTE_W-1:0];
            end else st_r <= S_IDLE;
          end else begin
            unk_r <= ({1'b0, q_cmd.code} >= 13'(next_free_r));
            c_r   <= ({1'b0, q_cmd.code} >= 13'(next_free_r)) ? prev_r : q_cmd.code;
            lim_r <= ({1'b0, q_cmd.code} >= 13'(next_free_r)) ? NW'(STACK_DEPTH - 1)
                                                              : NW'(STACK_DEPTH);
            n_r   <= '0;
            st_r  <= S_READ;
          end
        end
        S_READ: st_r <= S_WALK;
        S_WALK: begin
          if (n_r >= lim_r) st_r <= S_ERR;
          else if (c_r < 12'(LITERAL_LIMIT)) begin
            first_r <= c_r[BYTE_W-1:0];
            n_r <= n_r + NW'(1);
            if (next_free_r < (AW+1)'(DSZ)) next_free_r <= next_free_r + (AW+1)'(1);
            st_r <= S_POP;
          end else begin
            n_r <= n_r + NW'(1);
            c_r <= rd_pre_r;
            st_r <= S_READ;
          end
        end
        S_POP: if (slot) begin
          ob_r <= stack_mem[n_r[SW-1:0] - SW'(1)];
          ol_r <= (n_r == NW'(1)) && !unk_r;
          oe_r <= 1'b0;
          n_r  <= n_r - NW'(1);
          if (n_r == NW'(1)) begin
            if (unk_r) st_r <= S_EXTRA;
            else begin
              prev_r <= cur_r; fop_r <= first_r; st_r <= S_IDLE;
            end
          end
        end
        S_EXTRA: if (slot) begin
          ob_r <= fop_r; ol_r <= 1'b1; oe_r <= 1'b0;
          prev_r <= cur_r; fop_r <= first_r; st_r <= S_IDLE;
        end
        S_ERR: if (slot) begin
          ob_r <= '0; ol_r <= 1'b1; oe_r <= 1'b1; st_r <= S_IDLE;
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

>>> hdl/lzw_code_decoder.sv
// ----------------------------------------------------------------------------
// lzw_code_decoder
// variable width lzw decoder: one code in, its string out a byte at a time
// ----------------------------------------------------------------------------
// path: the opening code of a stream goes through the queue straight to the
//   output register; a later literal through the queue, read, walk and pop states
// states: an idle state per code, a read and a walk state per chain entry
//   (registered dictionary read), a pop per byte, an extra for an unknown code
// widening codes are dropped in the front and give no output
// reset: synchronous rst_n clears control, width 9, next free entry 256;
//   dictionary contents stay undefined until written
module lzw_code_decoder
  import lzwd_pkg::*;
#(
  parameter int unsigned MAX_CODE_BITS = MAX_CODE_BITS_DEF,
  parameter int unsigned STACK_DEPTH   = STACK_DEPTH_DEF
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            cfg_we,
  input  logic [CW_W-1:0] cfg_wdata,
  lzwd_code_if.sink       in_if,
  lzwd_res_if.source      out_if
);
  logic      q_valid, q_ready;
  lzwd_cmd_t q_cmd;

  // front: width tracking, widening codes dropped, two entry queue
  lzwd_front #(.MAX_CODE_BITS(MAX_CODE_BITS)) u_front (
    .clk, .rst_n, .cfg_we, .cfg_wdata,
    .in_valid(in_if.valid), .in_ready(in_if.ready), .in_code(in_if.code),
    .q_valid, .q_ready, .q_cmd
  );

  // back: chain walk, stack pop, dictionary update
  lzwd_back #(.MAX_CODE_BITS(MAX_CODE_BITS), .STACK_DEPTH(STACK_DEPTH)) u_back (
    .clk, .rst_n, .q_valid, .q_ready, .q_cmd,
    .out_valid(out_if.valid), .out_ready(out_if.ready),
    .out_data_byte(out_if.data_byte), .out_last_byte(out_if.last_byte),
    .out_error(out_if.error)
  );
endmodule

>>> hdl/lzwd_checker.sv
// ----------------------------------------------------------------------------
// lzwd_checker
// port level checks for the decoder
// ----------------------------------------------------------------------------
module lzwd_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_data_byte,
  input logic       out_last_byte,
  input logic       out_error
);
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data_byte))
    else $error("result dropped under stall");
  a_err_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_error |-> out_last_byte && out_data_byte == 8'd0)
    else $error("error result malformed");
  a_rst: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("valid after reset");
endmodule

bind lzw_code_decoder lzwd_checker u_chk (
  .clk, .rst_n, .out_valid(out_if.valid), .out_ready(out_if.ready),
  .out_data_byte(out_if.data_byte), .out_last_byte(out_if.last_byte),
  .out_error(out_if.error)
);
